### rtl/core/wsp_pkg.sv
`timescale 1ns / 1ps

package wsp_pkg;

  localparam int CFG_IDX_W = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_VIEW_COL0 = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_VIEW_COL1 = 4'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_VIEW_COL2 = 4'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_VIEW_COL3 = 4'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PROJ_COL0 = 4'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_PROJ_COL1 = 4'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_PROJ_COL2 = 4'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_PROJ_COL3 = 4'd7;

  localparam logic [31:0] NEG_ONE_Q16 = 32'hFFFF_0000;
  localparam logic [31:0] ONE_Q16     = 32'h0001_0000;
  localparam logic [31:0] SAT_MAX     = 32'h7FFF_FFFF;
  localparam logic [31:0] SAT_MIN     = 32'h8000_0000;

  // quotient bits produced by the divider, one per stage
  localparam int DIV_STAGES = 32;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
  } wsp_in_t;

  typedef struct packed {
    logic signed [31:0] screen_x;
    logic signed [31:0] screen_y;
    logic               visible;
  } wsp_out_t;

  // column-major, row j of a column at bits 16j
  typedef logic [3:0][63:0] wsp_mat_t;
  typedef logic [3:0][31:0] wsp_vec4_t;

  typedef struct packed {
    logic vld;
    logic inv;
  } wsp_ctl_t;

  function automatic logic [31:0] sat32(input logic [49:0] v);
    if (v[49:31] == {19{1'b0}} || v[49:31] == {19{1'b1}})
      return v[31:0];
    else if (v[49])
      return SAT_MIN;
    else
      return SAT_MAX;
  endfunction

endpackage

### rtl/core/wsp_matvec.sv
`timescale 1ns / 1ps

module wsp_matvec (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  wsp_pkg::wsp_ctl_t  ctl_in,
  input  wsp_pkg::wsp_mat_t  mat,
  input  wsp_pkg::wsp_vec4_t vec_in,
  output wsp_pkg::wsp_ctl_t  ctl_out,
  output wsp_pkg::wsp_vec4_t vec_out
);
  import wsp_pkg::*;

  logic signed [47:0] prod_nxt [4][4];
  logic signed [47:0] prod_r   [4][4];
  wsp_ctl_t           ctl1_r;
  wsp_ctl_t           ctl2_r;
  wsp_vec4_t          vec_nxt;
  wsp_vec4_t          vec_r;
  logic signed [49:0] sum;
  logic signed [49:0] shr;

  // stage 1: sixteen products
  always_comb begin
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        prod_nxt[r][c] = $signed(mat[c][16*r +: 16]) * $signed(vec_in[c]);
      end
    end
  end

  // stage 2: row sums, floor to Q16.16, saturate
  always_comb begin
    sum = '0;
    shr = '0;
    for (int r = 0; r < 4; r++) begin
      sum = $signed({{2{prod_r[r][0][47]}}, prod_r[r][0]})
          + $signed({{2{prod_r[r][1][47]}}, prod_r[r][1]})
          + $signed({{2{prod_r[r][2][47]}}, prod_r[r][2]})
          + $signed({{2{prod_r[r][3][47]}}, prod_r[r][3]});
      shr = sum >>> 12;
      vec_nxt[r] = sat32(shr);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl1_r <= '0;
      ctl2_r <= '0;
    end else if (en) begin
      ctl1_r <= ctl_in;
      ctl2_r <= ctl1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= prod_nxt;
      vec_r  <= vec_nxt;
    end
  end

  assign ctl_out = ctl2_r;
  assign vec_out = vec_r;

endmodule

### rtl/core/wsp_div.sv
`timescale 1ns / 1ps

module wsp_div (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  wsp_pkg::wsp_ctl_t  ctl_in,
  input  wsp_pkg::wsp_vec4_t clip,
  output wsp_pkg::wsp_ctl_t  ctl_out,
  output logic [31:0]        quo_x,
  output logic [31:0]        quo_y
);
  import wsp_pkg::*;

  typedef struct packed {
    logic [31:0] rem;
    logic [31:0] num;
    logic [31:0] quo;
    logic        neg;
    logic        ovf;
  } wsp_lane_t;

  wsp_lane_t   lx_r  [DIV_STAGES+1];
  wsp_lane_t   ly_r  [DIV_STAGES+1];
  logic [31:0] den_r [DIV_STAGES+1];
  wsp_ctl_t    ctl_r [DIV_STAGES+1];

  logic [32:0] sum_x;
  logic [32:0] sum_y;
  logic [47:0] num_x;
  logic [47:0] num_y;
  logic [47:0] abs_x;
  logic [47:0] abs_y;
  logic [31:0] abs_d;
  wsp_lane_t   lx_nxt;
  wsp_lane_t   ly_nxt;

  // prep: numerators times 2^15, magnitudes, overflow when quotient >= 2^32
  always_comb begin
    sum_x = {clip[0][31], clip[0]} + {clip[3][31], clip[3]};
    sum_y = {clip[3][31], clip[3]} - {clip[1][31], clip[1]};
    num_x = {sum_x, 15'b0};
    num_y = {sum_y, 15'b0};
    abs_x = num_x[47] ? (48'd0 - num_x) : num_x;
    abs_y = num_y[47] ? (48'd0 - num_y) : num_y;
    abs_d = clip[3][31] ? (32'd0 - clip[3]) : clip[3];
    lx_nxt.rem = {16'b0, abs_x[47:32]};
    lx_nxt.num = abs_x[31:0];
    lx_nxt.quo = '0;
    lx_nxt.neg = num_x[47] ^ clip[3][31];
    lx_nxt.ovf = {16'b0, abs_x[47:32]} >= abs_d;
    ly_nxt.rem = {16'b0, abs_y[47:32]};
    ly_nxt.num = abs_y[31:0];
    ly_nxt.quo = '0;
    ly_nxt.neg = num_y[47] ^ clip[3][31];
    ly_nxt.ovf = {16'b0, abs_y[47:32]} >= abs_d;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r[0] <= '0;
    end else if (en) begin
      ctl_r[0] <= ctl_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lx_r[0]  <= lx_nxt;
      ly_r[0]  <= ly_nxt;
      den_r[0] <= abs_d;
    end
  end

  // restoring division, one quotient bit per stage
  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_step
    logic [32:0] tx;
    logic [32:0] ty;
    logic [32:0] dx;
    logic [32:0] dy;
    wsp_lane_t   sx_nxt;
    wsp_lane_t   sy_nxt;

    always_comb begin
      tx = {lx_r[k].rem, lx_r[k].num[31]};
      ty = {ly_r[k].rem, ly_r[k].num[31]};
      dx = tx - {1'b0, den_r[k]};
      dy = ty - {1'b0, den_r[k]};
      sx_nxt     = lx_r[k];
      sy_nxt     = ly_r[k];
      sx_nxt.num = {lx_r[k].num[30:0], 1'b0};
      sy_nxt.num = {ly_r[k].num[30:0], 1'b0};
      if (tx >= {1'b0, den_r[k]}) begin
        sx_nxt.rem = dx[31:0];
        sx_nxt.quo = {lx_r[k].quo[30:0], 1'b1};
      end else begin
        sx_nxt.rem = tx[31:0];
        sx_nxt.quo = {lx_r[k].quo[30:0], 1'b0};
      end
      if (ty >= {1'b0, den_r[k]}) begin
        sy_nxt.rem = dy[31:0];
        sy_nxt.quo = {ly_r[k].quo[30:0], 1'b1};
      end else begin
        sy_nxt.rem = ty[31:0];
        sy_nxt.quo = {ly_r[k].quo[30:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        ctl_r[k+1] <= '0;
      end else if (en) begin
        ctl_r[k+1] <= ctl_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        lx_r[k+1]  <= sx_nxt;
        ly_r[k+1]  <= sy_nxt;
        den_r[k+1] <= den_r[k];
      end
    end
  end

  function automatic logic [31:0] signed_sat(input wsp_lane_t l);
    if (l.neg) begin
      if (l.ovf || l.quo > SAT_MIN)
        return SAT_MIN;
      else
        return 32'd0 - l.quo;
    end else begin
      if (l.ovf || l.quo[31])
        return SAT_MAX;
      else
        return l.quo;
    end
  endfunction

  assign ctl_out = ctl_r[DIV_STAGES];
  assign quo_x   = signed_sat(lx_r[DIV_STAGES]);
  assign quo_y   = signed_sat(ly_r[DIV_STAGES]);

endmodule

### rtl/core/world_to_screen_projection.sv
`timescale 1ns / 1ps
// channel | ports                              | dir | beat
// input   | in_valid, in_stall, in_data        | in  | world point x,y,z Q16.16
// result  | out_valid, out_stall, out_data     | out | screen x,y Q16.16, visible
// config  | cfg_valid, cfg_ready, cfg_index/data | in  | one 64-bit matrix column
//
// One point per cycle unless out_stall freezes the pipeline; stages: two 2-stage
// matrix products, divider prep, 32 divider stages of one quotient bit, output reg.
// Reset is synchronous on rst_n low; matrices clear to zero.
// out_stall with a result waiting freezes the whole pipeline and raises in_stall.
// cfg_ready is always high.

module world_to_screen_projection (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  wsp_pkg::wsp_in_t              in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output wsp_pkg::wsp_out_t             out_data,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [wsp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [63:0]                   cfg_data
);
  import wsp_pkg::*;

  wsp_mat_t  view_r;
  wsp_mat_t  proj_r;
  logic      en;
  wsp_ctl_t  ctl_in;
  wsp_vec4_t pt;
  wsp_ctl_t  view_ctl;
  wsp_vec4_t view_vec;
  wsp_ctl_t  proj_ctl_in;
  wsp_ctl_t  proj_ctl;
  wsp_vec4_t clip_vec;
  wsp_ctl_t  div_ctl_in;
  wsp_ctl_t  div_ctl;
  logic [31:0] quo_x;
  logic [31:0] quo_y;
  logic      out_valid_r;
  wsp_out_t  out_r;
  wsp_out_t  out_nxt;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      view_r <= '0;
      proj_r <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_VIEW_COL0: view_r[0] <= cfg_data;
        CFG_VIEW_COL1: view_r[1] <= cfg_data;
        CFG_VIEW_COL2: view_r[2] <= cfg_data;
        CFG_VIEW_COL3: view_r[3] <= cfg_data;
        CFG_PROJ_COL0: proj_r[0] <= cfg_data;
        CFG_PROJ_COL1: proj_r[1] <= cfg_data;
        CFG_PROJ_COL2: proj_r[2] <= cfg_data;
        CFG_PROJ_COL3: proj_r[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  assign en       = !out_valid_r || !out_stall;
  assign in_stall = !en;

  always_comb begin
    ctl_in.vld = in_valid;
    ctl_in.inv = (in_data.pos_x == NEG_ONE_Q16) && (in_data.pos_y == NEG_ONE_Q16)
              && (in_data.pos_z == NEG_ONE_Q16);
    pt[0] = in_data.pos_x;
    pt[1] = in_data.pos_y;
    pt[2] = in_data.pos_z;
    pt[3] = ONE_Q16;
  end

  wsp_matvec u_view (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .ctl_in  (ctl_in),
    .mat     (view_r),
    .vec_in  (pt),
    .ctl_out (view_ctl),
    .vec_out (view_vec)
  );

  // behind the camera: view-space z strictly positive
  always_comb begin
    proj_ctl_in.vld = view_ctl.vld;
    proj_ctl_in.inv = view_ctl.inv || (!view_vec[2][31] && view_vec[2] != 32'd0);
  end

  wsp_matvec u_proj (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .ctl_in  (proj_ctl_in),
    .mat     (proj_r),
    .vec_in  (view_vec),
    .ctl_out (proj_ctl),
    .vec_out (clip_vec)
  );

  always_comb begin
    div_ctl_in.vld = proj_ctl.vld;
    div_ctl_in.inv = proj_ctl.inv || (clip_vec[3] == 32'd0);
  end

  wsp_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .ctl_in  (div_ctl_in),
    .clip    (clip_vec),
    .ctl_out (div_ctl),
    .quo_x   (quo_x),
    .quo_y   (quo_y)
  );

  always_comb begin
    if (div_ctl.inv) begin
      out_nxt.screen_x = NEG_ONE_Q16;
      out_nxt.screen_y = NEG_ONE_Q16;
      out_nxt.visible  = 1'b0;
    end else begin
      out_nxt.screen_x = quo_x;
      out_nxt.screen_y = quo_y;
      out_nxt.visible  = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= div_ctl.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_inv_marker: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_r.visible |->
      out_r.screen_x == NEG_ONE_Q16 && out_r.screen_y == NEG_ONE_Q16)
    else $error("invalid result without marker value");

  a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(out_r) && out_valid_r)
    else $error("pipeline moved while frozen");

  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid_r)
    else $error("result valid after reset");

  a_stall_path: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid_r && out_stall)
    else $error("input stalled without a blocked result");

endmodule
